// ===== hw/rtl/pcm_format_convert_downmix_assert.svh =====
// ----------------------------------------------------------------------------
// PCM converter assertion macros
// Concurrent assertion shorthands that the converter's RTL uses.
// ----------------------------------------------------------------------------
`ifndef PCM_FORMAT_CONVERT_DOWNMIX_ASSERT_SVH
`define PCM_FORMAT_CONVERT_DOWNMIX_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCMFCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCMFCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pcmfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM converter package
// Sequencer states, format codes and register indexes of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmfcd_pkg;

	// Source sample formats; codes above FMT_F32 decode as signed 32-bit.
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S16 = 3'd1;
	localparam logic [2:0] FMT_S24 = 3'd2;
	localparam logic [2:0] FMT_S32 = 3'd3;
	localparam logic [2:0] FMT_F32 = 3'd4;

	// Target formats.
	localparam logic TGT_S16 = 1'b0;
	localparam logic TGT_F32 = 1'b1;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_SOURCE_FORMAT   = 2'd0;
	localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd1;
	localparam logic [1:0] REG_FORCE_MONO      = 2'd2;
	localparam logic [1:0] REG_TARGET_FORMAT   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_ROUTE,
		ST_DLOAD,
		ST_DIV,
		ST_PACK,
		ST_S16,
		ST_FNORM,
		ST_FROUND,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcm_format_convert_downmix.sv =====
// ----------------------------------------------------------------------------
// PCM format converter with mono downmix
// Converts u8, s16, s24, s32 or float32 sample words to S16 or float32,
// optionally averaging all channels of a frame into one output word.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Protocol  Contents
// s_*       in   stream    tdata: sample_word
// m_*       out  stream    tdata: out_sample, tuser: out_channel, tlast: frame_done
// p*        in   APB       source_format, source_channels, force_mono, target_format
//
// One word is processed at a time by a small sequencer around a single shared
// work register that serves as restoring divider, float normalizer and S16
// scaler. A word that stays in one channel passes normalize and route, then is
// scaled for S16, goes straight out on float passthrough, or is normalized (the
// loop shifts by eight or by one per cycle) and rounded for float32. A downmixed
// word that is not the last of its frame only passes normalize and route; the
// last adds a load step and one divider cycle per quotient bit before packing.
// The reset is asynchronous, sets the registers to their defaults and clears
// the frame position and the mix accumulator. The output word sits in a register,
// so the next input word is taken while a result still waits; the sequencer
// only stalls when a new result is ready and the previous one has not been taken.
//
`default_nettype none

module pcm_format_convert_downmix #(
	parameter int MAX_CHANNELS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,    // [31:0] sample_word
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,    // [31:0] out_sample
	output logic [2:0]       m_tuser,    // [2:0] out_channel
	output logic             m_tlast,    // frame_done
	// Register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

`include "pcm_format_convert_downmix_assert.svh"

	// Channel count, position, accumulator and divider widths all follow the
	// channel limit.
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ACC_W  = 33 + $clog2(MAX_CHANNELS);
	localparam int DIV_W  = ACC_W + 1;
	localparam int DV_W   = CH_W + 1;
	localparam int WORK_W = (DIV_W > 47) ? DIV_W : 47;
	localparam int CNT_W  = $clog2(DIV_W);

	// Float32 to Q2.31 with round half away from zero and saturation to
	// [-2^32, 2^32-1]. NaN and subnormals give zero, infinity saturates.
	function automatic logic signed [32:0] float_to_q(input logic [31:0] w);
		logic [7:0]  e;
		logic [33:0] m;
		logic [33:0] mag;
		logic [4:0]  r;
		logic        sat;
		logic        zero;
		logic signed [32:0] q;
		e    = w[30:23];
		m    = {10'd0, 1'b1, w[22:0]};
		mag  = '0;
		r    = '0;
		sat  = 1'b0;
		zero = 1'b0;
		if (e == 8'hFF) begin
			if (w[22:0] != 23'd0) zero = 1'b1;
			else sat = 1'b1;
		end else if (e == 8'd0) begin
			zero = 1'b1;
		end else if (e > 8'd128) begin
			sat = 1'b1;
		end else if (e >= 8'd119) begin
			mag = m << (e - 8'd119);
		end else if (e < 8'd95) begin
			zero = 1'b1;
		end else begin
			r   = 5'(8'd119 - e);
			mag = (m + (34'd1 << (r - 5'd1))) >> r;
		end
		if (zero) begin
			q = '0;
		end else if (w[31]) begin
			if (sat || mag >= 34'h1_0000_0000) q = 33'sh1_0000_0000;
			else q = $signed(33'd0 - mag[32:0]);
		end else begin
			if (sat || mag > 34'h0_FFFF_FFFF) q = 33'sh0_FFFF_FFFF;
			else q = $signed(mag[32:0]);
		end
		return q;
	endfunction

	// Configuration registers.
	logic [2:0] source_format_q;
	logic [3:0] source_channels_q;
	logic       force_mono_q;
	logic       target_format_q;

	// Sequencer and frame state.
	pcmfcd_pkg::state_t state_q, state_d;
	logic [POS_W-1:0]        pos_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [5:0]              sh_q;

	// Per-word data registers.
	logic [31:0]             word_q;
	logic signed [32:0]      norm_q;
	logic [WORK_W-1:0]       work_q;
	logic [DV_W-1:0]         rem_q;
	logic                    sign_q;
	logic [31:0]             res_q;
	logic [2:0]              chan_q;
	logic                    done_q;

	// Output register.
	logic                    m_tvalid_q;
	logic [31:0]             m_tdata_q;
	logic [2:0]              m_tuser_q;
	logic                    m_tlast_q;

	logic cfg_wr;
	logic in_fire;
	logic out_free;

	// Frame bookkeeping, evaluated in the route step.
	logic [4:0]              ch5;
	logic [4:0]              pos5;
	logic [4:0]              pos_eff5;
	logic [4:0]              pos_next5;
	logic                    stale;
	logic                    last;
	logic                    mixing;
	logic                    passthru;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] mix_sum;
	logic [32:0]             norm_abs;
	logic signed [32:0]      norm_val;

	// Shared work register views.
	logic signed [ACC_W-1:0] sum_saved;
	logic signed [DIV_W-1:0] sum_ext;
	logic [DIV_W-1:0]        sum_twice;
	logic [DIV_W-1:0]        ch_ext;
	logic [DIV_W-1:0]        numer;
	logic [DV_W-1:0]         divisor;
	logic [DV_W:0]           rem_try;
	logic [DV_W:0]           rem_sub;
	logic                    quo_bit;
	logic [32:0]             mag;
	logic [31:0]             mag_clamp;
	logic [15:0]             s16_mag;
	logic [7:0]              exp8;
	logic [30:0]             f_body;
	logic                    f_round;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == pcmfcd_pkg::ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			pcmfcd_pkg::REG_SOURCE_FORMAT:   prdata = {29'd0, source_format_q};
			pcmfcd_pkg::REG_SOURCE_CHANNELS: prdata = {28'd0, source_channels_q};
			pcmfcd_pkg::REG_FORCE_MONO:      prdata = {31'd0, force_mono_q};
			pcmfcd_pkg::REG_TARGET_FORMAT:   prdata = {31'd0, target_format_q};
			default:                         prdata = '0;
		endcase
	end

	// Raw word to Q2.31. Unknown format codes read the word as signed 32-bit.
	always_comb begin
		case (source_format_q)
			pcmfcd_pkg::FMT_U8:  norm_val = $signed({{2{~word_q[7]}}, word_q[6:0], 24'd0});
			pcmfcd_pkg::FMT_S16: norm_val = $signed({word_q[15], word_q[15:0], 16'd0});
			pcmfcd_pkg::FMT_S24: norm_val = $signed({word_q[23], word_q[23:0], 8'd0});
			pcmfcd_pkg::FMT_F32: norm_val = float_to_q(word_q);
			default:             norm_val = $signed({word_q[31], word_q});
		endcase
	end

	// Effective channel count: zero counts as one, and the count saturates at
	// the channel limit. A position left over from an older count restarts
	// the frame.
	always_comb begin
		if (source_channels_q == 4'd0) ch5 = 5'd1;
		else if ({1'b0, source_channels_q} > 5'(MAX_CHANNELS)) ch5 = 5'(MAX_CHANNELS);
		else ch5 = {1'b0, source_channels_q};
		pos5      = 5'(pos_q);
		stale     = (pos5 >= ch5);
		pos_eff5  = stale ? 5'd0 : pos5;
		last      = (pos_eff5 == ch5 - 5'd1);
		pos_next5 = last ? 5'd0 : pos_eff5 + 5'd1;
		mixing    = force_mono_q && (ch5 > 5'd1);
		passthru  = (target_format_q == pcmfcd_pkg::TGT_F32)
			&& (source_format_q == pcmfcd_pkg::FMT_F32);
		acc_base  = stale ? '0 : acc_q;
		mix_sum   = acc_base + ACC_W'(norm_q);
		norm_abs  = norm_q[32] ? (33'd0 - norm_q) : norm_q;
	end

	// Divider: the numerator is 2*|sum| + n and the divisor 2*n, which rounds
	// the average half away from zero.
	always_comb begin
		sum_saved = $signed(work_q[ACC_W-1:0]);
		sum_ext   = DIV_W'(sum_saved);
		sum_twice = {sum_ext[DIV_W-2:0], 1'b0};
		ch_ext    = DIV_W'(ch5);
		numer     = sum_saved[ACC_W-1] ? (ch_ext - sum_twice) : (sum_twice + ch_ext);
		divisor   = {ch5[CH_W-1:0], 1'b0};
		rem_try   = {rem_q, work_q[DIV_W-1]};
		rem_sub   = rem_try - {1'b0, divisor};
		quo_bit   = (rem_try >= {1'b0, divisor});
	end

	// Packing views of the magnitude held in the low bits of the work register.
	always_comb begin
		mag       = work_q[32:0];
		mag_clamp = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
		s16_mag   = work_q[46:31];
		// After normalizing, the leading one sits at bit 32, so the exponent
		// is 128 minus the shift count.
		exp8      = 8'd128 - {2'b00, sh_q};
		f_body    = {exp8, work_q[31:9]};
		f_round   = work_q[8] && ((|work_q[7:0]) || work_q[9]);
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcmfcd_pkg::ST_IDLE: begin
				if (in_fire) state_d = pcmfcd_pkg::ST_NORM;
			end
			pcmfcd_pkg::ST_NORM: state_d = pcmfcd_pkg::ST_ROUTE;
			pcmfcd_pkg::ST_ROUTE: begin
				if (mixing) begin
					state_d = last ? pcmfcd_pkg::ST_DLOAD : pcmfcd_pkg::ST_IDLE;
				end else if (passthru) begin
					state_d = pcmfcd_pkg::ST_OUT;
				end else begin
					state_d = pcmfcd_pkg::ST_PACK;
				end
			end
			pcmfcd_pkg::ST_DLOAD: state_d = pcmfcd_pkg::ST_DIV;
			pcmfcd_pkg::ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_W - 1)) state_d = pcmfcd_pkg::ST_PACK;
			end
			pcmfcd_pkg::ST_PACK: begin
				if (target_format_q == pcmfcd_pkg::TGT_S16) state_d = pcmfcd_pkg::ST_S16;
				else if (mag == 33'd0) state_d = pcmfcd_pkg::ST_OUT;
				else state_d = pcmfcd_pkg::ST_FNORM;
			end
			pcmfcd_pkg::ST_S16: state_d = pcmfcd_pkg::ST_OUT;
			pcmfcd_pkg::ST_FNORM: begin
				if (work_q[32]) state_d = pcmfcd_pkg::ST_FROUND;
			end
			pcmfcd_pkg::ST_FROUND: state_d = pcmfcd_pkg::ST_OUT;
			pcmfcd_pkg::ST_OUT: begin
				if (out_free) state_d = pcmfcd_pkg::ST_IDLE;
			end
			default: state_d = pcmfcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcmfcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: registers, frame position, accumulator, counters and
	// the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q   <= pcmfcd_pkg::FMT_S16;
			source_channels_q <= 4'd2;
			force_mono_q      <= 1'b0;
			target_format_q   <= pcmfcd_pkg::TGT_S16;
			pos_q             <= '0;
			acc_q             <= '0;
			cnt_q             <= '0;
			sh_q              <= '0;
			m_tvalid_q        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					pcmfcd_pkg::REG_SOURCE_FORMAT:   source_format_q   <= pwdata[2:0];
					pcmfcd_pkg::REG_SOURCE_CHANNELS: source_channels_q <= pwdata[3:0];
					pcmfcd_pkg::REG_FORCE_MONO:      force_mono_q      <= pwdata[0];
					pcmfcd_pkg::REG_TARGET_FORMAT:   target_format_q   <= pwdata[0];
					default: ;
				endcase
			end

			if (state_q == pcmfcd_pkg::ST_ROUTE) begin
				pos_q <= pos_next5[POS_W-1:0];
				// Pass mode and the end of a mixed frame both clear the sum.
				if (mixing && !last) acc_q <= mix_sum;
				else acc_q <= '0;
			end

			if (state_q == pcmfcd_pkg::ST_DLOAD) cnt_q <= '0;
			else if (state_q == pcmfcd_pkg::ST_DIV) cnt_q <= cnt_q + CNT_W'(1);

			if (state_q == pcmfcd_pkg::ST_PACK) begin
				sh_q <= '0;
			end else if (state_q == pcmfcd_pkg::ST_FNORM && !work_q[32]) begin
				sh_q <= (work_q[32:25] == 8'd0) ? sh_q + 6'd8 : sh_q + 6'd1;
			end

			if (state_q == pcmfcd_pkg::ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Datapath. The work register carries the sum, the divider numerator and
	// quotient, the magnitude being packed and the S16 product in turn.
	always_ff @(posedge clk) begin
		if (in_fire) word_q <= s_tdata;

		case (state_q)
			pcmfcd_pkg::ST_NORM: begin
				norm_q <= norm_val;
			end
			pcmfcd_pkg::ST_ROUTE: begin
				if (mixing) begin
					work_q <= WORK_W'($unsigned(mix_sum));
					chan_q <= 3'd0;
					done_q <= 1'b1;
				end else begin
					sign_q <= norm_q[32];
					work_q <= WORK_W'(norm_abs);
					res_q  <= word_q;
					chan_q <= pos_eff5[2:0];
					done_q <= last;
				end
			end
			pcmfcd_pkg::ST_DLOAD: begin
				sign_q <= sum_saved[ACC_W-1];
				work_q <= WORK_W'(numer);
				rem_q  <= '0;
			end
			pcmfcd_pkg::ST_DIV: begin
				// One restoring step: shift in the next numerator bit and keep
				// the quotient bit in the vacated low end.
				rem_q <= quo_bit ? rem_sub[DV_W-1:0] : rem_try[DV_W-1:0];
				work_q[DIV_W-1:0] <= {work_q[DIV_W-2:0], quo_bit};
			end
			pcmfcd_pkg::ST_PACK: begin
				if (target_format_q == pcmfcd_pkg::TGT_S16) begin
					// |v| * 32767 plus half an output step.
					work_q <= (WORK_W'(mag_clamp) << 15) - WORK_W'(mag_clamp)
						+ (WORK_W'(1) << 30);
				end else if (mag == 33'd0) begin
					res_q <= 32'd0;
				end
			end
			pcmfcd_pkg::ST_S16: begin
				res_q <= {16'd0, sign_q ? (16'd0 - s16_mag) : s16_mag};
			end
			pcmfcd_pkg::ST_FNORM: begin
				if (!work_q[32]) begin
					if (work_q[32:25] == 8'd0) work_q <= WORK_W'({work_q[24:0], 8'd0});
					else work_q <= WORK_W'({work_q[31:0], 1'b0});
				end
			end
			pcmfcd_pkg::ST_FROUND: begin
				// A carry out of the mantissa bumps the exponent on its own.
				res_q <= {sign_q, f_body + 31'(f_round)};
			end
			pcmfcd_pkg::ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= res_q;
					m_tuser_q <= chan_q;
					m_tlast_q <= done_q;
				end
			end
			default: ;
		endcase
	end

	// An accepted word keeps the sequencer busy in the cycle after it is taken.
	`PCMFCD_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")

	// The frame position never reaches the channel limit.
	`PCMFCD_ASSERT_IMP(a_pos_in_range, clk, arst_n, 1'b1, 32'(pos_q) < MAX_CHANNELS, "frame position out of range")

	// The float normalize loop only runs on a nonzero magnitude, else it
	// would never find a leading one.
	`PCMFCD_ASSERT_IMP(a_fnorm_nonzero, clk, arst_n, state_q == pcmfcd_pkg::ST_FNORM, work_q[32:0] != 33'd0, "normalizing a zero magnitude")

endmodule

`default_nettype wire
